### rtl/urtb_pkg.sv
// ----------------------------------------------------------------------------
// urtb_pkg: shared types and codes for the UART receive/transmit ring buffers
// Request and status codes, byte width and the control word passed from the
// ring controller to the response stage.
// ----------------------------------------------------------------------------
package urtb_pkg;

   localparam int unsigned DEPTH_DEFAULT = 128;
   localparam int unsigned BYTE_W        = 8;

   typedef logic [1:0]        req_code_type;
   typedef logic [1:0]        stat_code_type;
   typedef logic [BYTE_W-1:0] byte_type;

   // request codes
   localparam req_code_type REQ_LINE_RX  = 2'd0;
   localparam req_code_type REQ_SW_READ  = 2'd1;
   localparam req_code_type REQ_SW_WRITE = 2'd2;
   localparam req_code_type REQ_TX_READY = 2'd3;

   // status codes
   localparam stat_code_type STAT_OK       = 2'd0;
   localparam stat_code_type STAT_RX_EMPTY = 2'd1;
   localparam stat_code_type STAT_TX_FULL  = 2'd2;
   localparam stat_code_type STAT_RX_DROP  = 2'd3;

   // decision for one item, held until its response goes out
   typedef struct packed {
      stat_code_type status;
      logic          read_valid;
      logic          tx_valid;
      logic          tx_fwd;     // tx byte is the one written this item
   } rsp_info_type;

endpackage

### rtl/urtb_ram.sv
// ----------------------------------------------------------------------------
// urtb_ram: byte memory, one write port and one registered read port
// Read is read-first: a read and a write to the same entry in the same cycle
// return the old contents.
// ----------------------------------------------------------------------------
module urtb_ram #(
   parameter int unsigned DEPTH = urtb_pkg::DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [urtb_pkg::BYTE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [urtb_pkg::BYTE_W-1:0] rd_data
);
   import urtb_pkg::*;

   byte_type mem_ff [DEPTH];
   byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/urtb_ctrl.sv
// ----------------------------------------------------------------------------
// urtb_ctrl: ring pointer control
// Holds head/tail of both rings, decides full/empty per item and issues the
// memory reads and writes for the accepted item.
// ----------------------------------------------------------------------------
module urtb_ctrl #(
   parameter int unsigned DEPTH = urtb_pkg::DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [1:0]                   req_code,
   input  logic                         tx_idle,
   output logic                         rx_wr_en,
   output logic [$clog2(DEPTH)-1:0]     rx_wr_addr,
   output logic                         rx_rd_en,
   output logic [$clog2(DEPTH)-1:0]     rx_rd_addr,
   output logic                         tx_wr_en,
   output logic [$clog2(DEPTH)-1:0]     tx_wr_addr,
   output logic                         tx_rd_en,
   output logic [$clog2(DEPTH)-1:0]     tx_rd_addr,
   output urtb_pkg::rsp_info_type       info
);
   import urtb_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
   endfunction

   logic [PTR_W-1:0] rx_head_ff, rx_head_in;
   logic [PTR_W-1:0] rx_tail_ff, rx_tail_in;
   logic [PTR_W-1:0] tx_head_ff, tx_head_in;
   logic [PTR_W-1:0] tx_tail_ff, tx_tail_in;

   logic rx_full, rx_empty, tx_full, tx_empty;

   assign rx_full  = (wrap_inc(rx_head_ff) == rx_tail_ff);
   assign rx_empty = (rx_head_ff == rx_tail_ff);
   assign tx_full  = (wrap_inc(tx_head_ff) == tx_tail_ff);
   assign tx_empty = (tx_head_ff == tx_tail_ff);

   assign rx_wr_addr = rx_head_ff;
   assign rx_rd_addr = rx_tail_ff;
   assign tx_wr_addr = tx_head_ff;
   assign tx_rd_addr = tx_tail_ff;

   always_comb begin
      rx_head_in = rx_head_ff;
      rx_tail_in = rx_tail_ff;
      tx_head_in = tx_head_ff;
      tx_tail_in = tx_tail_ff;
      rx_wr_en   = 1'b0;
      rx_rd_en   = 1'b0;
      tx_wr_en   = 1'b0;
      tx_rd_en   = 1'b0;
      info       = '{status: STAT_OK, read_valid: 1'b0, tx_valid: 1'b0, tx_fwd: 1'b0};
      if (accept) begin
         unique case (req_code)
            REQ_LINE_RX: begin
               if (rx_full) begin
                  info.status = STAT_RX_DROP;
               end else begin
                  rx_wr_en   = 1'b1;
                  rx_head_in = wrap_inc(rx_head_ff);
               end
            end
            REQ_SW_READ: begin
               if (rx_empty) begin
                  info.status = STAT_RX_EMPTY;
               end else begin
                  rx_rd_en        = 1'b1;
                  info.read_valid = 1'b1;
                  rx_tail_in      = wrap_inc(rx_tail_ff);
               end
            end
            REQ_SW_WRITE: begin
               if (tx_full) begin
                  info.status = STAT_TX_FULL;
               end else begin
                  tx_wr_en   = 1'b1;
                  tx_head_in = wrap_inc(tx_head_ff);
                  if (tx_idle) begin
                     // transmitter idle: an empty ring passes the byte straight through, else the oldest byte is read
                     tx_rd_en      = !tx_empty;
                     info.tx_valid = 1'b1;
                     info.tx_fwd   = tx_empty;
                     tx_tail_in    = wrap_inc(tx_tail_ff);
                  end
               end
            end
            REQ_TX_READY: begin
               if (!tx_empty) begin
                  tx_rd_en      = 1'b1;
                  info.tx_valid = 1'b1;
                  tx_tail_in    = wrap_inc(tx_tail_ff);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_head_ff <= '0;
         rx_tail_ff <= '0;
         tx_head_ff <= '0;
         tx_tail_ff <= '0;
      end else begin
         rx_head_ff <= rx_head_in;
         rx_tail_ff <= rx_tail_in;
         tx_head_ff <= tx_head_in;
         tx_tail_ff <= tx_tail_in;
      end
   end

endmodule

### rtl/uart_rx_tx_ring_buffers_top.sv
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers_top: receive and transmit byte rings for a UART
//
// Two rings of DEPTH slots, each holding up to DEPTH-1 bytes, in two byte
// memories with registered read data.
// Request channel: an item is taken on a rising edge with start high and
// busy low. req_type selects line byte received, software read, software
// write or transmitter ready; req_data_byte and req_tx_idle go with it.
// Response channel: one item per request, on the rsp_ ports for exactly one
// cycle with rsp_strobe high, the cycle after the request was taken. The
// receiver cannot stall, so nothing is ever held back.
// The response data comes from the registered memory read; a new request
// may be taken every cycle, since pointers update at the accept edge and a
// following read sees the previous write in the memory.
// A write to an empty transmit ring with the transmitter idle hands the
// written byte straight to the response (bypass around the memory).
// Reset (synchronous) clears all four pointers, so both rings are empty;
// busy is high for the cycle after reset. Memory contents are not cleared.
// ----------------------------------------------------------------------------
module uart_rx_tx_ring_buffers_top #(
   parameter int unsigned DEPTH = urtb_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic [urtb_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic                          req_tx_idle,
   // response channel
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status,
   output logic [urtb_pkg::BYTE_W-1:0]   rsp_read_byte,
   output logic                          rsp_read_valid,
   output logic [urtb_pkg::BYTE_W-1:0]   rsp_tx_byte,
   output logic                          rsp_tx_valid
);
   import urtb_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);

   logic             accept;
   logic             busy_ff;

   // memory command lines from the controller
   logic             rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
   logic [PTR_W-1:0] rx_wr_addr, rx_rd_addr, tx_wr_addr, tx_rd_addr;
   byte_type         rx_rd_data, tx_rd_data;

   // response stage
   rsp_info_type     info;
   rsp_info_type     info_ff;
   logic             rsp_valid_ff;
   byte_type         fwd_byte_ff;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // only held off right after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   urtb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_code   (req_type),
      .tx_idle    (req_tx_idle),
      .rx_wr_en   (rx_wr_en),
      .rx_wr_addr (rx_wr_addr),
      .rx_rd_en   (rx_rd_en),
      .rx_rd_addr (rx_rd_addr),
      .tx_wr_en   (tx_wr_en),
      .tx_wr_addr (tx_wr_addr),
      .tx_rd_en   (tx_rd_en),
      .tx_rd_addr (tx_rd_addr),
      .info       (info)
   );

   // receive ring storage
   urtb_ram #(.DEPTH(DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wr_addr),
      .wr_data (req_data_byte),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_rd_addr),
      .rd_data (rx_rd_data)
   );

   // transmit ring storage
   urtb_ram #(.DEPTH(DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_wr_addr),
      .wr_data (req_data_byte),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_rd_addr),
      .rd_data (tx_rd_data)
   );

   // decision and bypass byte ride along with the memory read
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         info_ff     <= info;
         fwd_byte_ff <= req_data_byte;
      end
   end

   assign rsp_strobe     = rsp_valid_ff;
   assign rsp_status     = info_ff.status;
   assign rsp_read_valid = info_ff.read_valid;
   assign rsp_read_byte  = info_ff.read_valid ? rx_rd_data : '0;
   assign rsp_tx_valid   = info_ff.tx_valid;
   assign rsp_tx_byte    = !info_ff.tx_valid ? '0 :
                           (info_ff.tx_fwd ? fwd_byte_ff : tx_rd_data);

   // every taken item gets its response on the next cycle, and only then
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("response missing after accepted item");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("response without an accepted item");

   // one item never both pops a received byte and feeds the transmitter
   a_one_pop_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_read_valid && rsp_tx_valid))
      else $error("read and transmit pop in the same item");

   // an empty or failed request never delivers data
   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STAT_OK) |-> (!rsp_read_valid && !rsp_tx_valid))
      else $error("data delivered with an error status");

endmodule
